@@ hdl/hcwp_pkg.sv @@
// Shared types and constants for the Huffman code word packer.
package hcwp_pkg;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int ENTRY_W   = CODE_W + LEN_W;
    localparam int MODE_W    = 2;
    localparam int SYM_W     = 16;
    localparam int S_TDATA_W = 56;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hcwp_item_t;

endpackage

@@ hdl/hcwp_code_mem.sv @@
// Code table memory: one write port, one registered read port.
module hcwp_code_mem
    import hcwp_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [2**ADDR_W];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/hcwp_packer.sv @@
// Bit accumulator, word splitter and output word buffer.
module hcwp_packer
    import hcwp_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  hcwp_item_t           item,
    output logic                 item_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_BITS-1:0] word,
    output logic                 m_tlast
);

    localparam int ACC_W     = WORD_BITS - 1 + CODE_W;
    localparam int TW        = $clog2(ACC_W + 1);
    localparam int MAX_WORDS = ACC_W / WORD_BITS;
    localparam int NW_W      = $clog2(MAX_WORDS + 1);
    localparam int PW        = $clog2(WORD_BITS);

    logic [WORD_BITS-2:0] acc_reg, acc_next;
    logic [PW-1:0]        pend_reg, pend_next;
    logic [NW_W-1:0]      ob_cnt_reg, ob_cnt_next;
    logic                 ob_last_reg, ob_last_next;
    logic [ACC_W-1:0]     ob_vec_reg, ob_vec_next;
    logic [TW-1:0]        ob_bits_reg, ob_bits_next;

    logic [LEN_W-1:0]     len_eff;
    logic [ACC_W-1:0]     code_mask;
    logic [ACC_W-1:0]     vec;
    logic [ACC_W-1:0]     flush_vec;
    logic [TW-1:0]        total;
    logic [TW-1:0]        rem;
    logic [NW_W-1:0]      nwords;
    logic [NW_W-1:0]      out_words;
    logic [TW-1:0]        sh;
    logic                 buf_free;
    logic                 fire;
    logic                 emit;

    always_comb
    begin
        len_eff   = (item.len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : item.len;
        code_mask = ~({ACC_W{1'b1}} << len_eff);
        vec       = (ACC_W'(acc_reg) << len_eff) | (ACC_W'(item.code) & code_mask);
        total     = TW'(pend_reg) + TW'(len_eff);
        nwords    = '0;
        rem       = total;
        for (int k = 1; k <= MAX_WORDS; k++)
        begin
            if (total >= TW'(k * WORD_BITS))
            begin
                nwords = NW_W'(k);
                rem    = total - TW'(k * WORD_BITS);
            end
        end
        flush_vec = ACC_W'(acc_reg) << (TW'(WORD_BITS) - TW'(pend_reg));
        case (item.mode)
            MODE_ENCODE: out_words = nwords;
            MODE_FLUSH:  out_words = NW_W'(1);
            default:     out_words = '0;
        endcase
    end

    assign m_tvalid   = (ob_cnt_reg != '0);
    assign emit       = m_tvalid && m_tready;
    assign buf_free   = (ob_cnt_reg == '0) || ((ob_cnt_reg == NW_W'(1)) && m_tready);
    assign item_ready = (out_words == '0) || buf_free;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        ob_cnt_next  = ob_cnt_reg;
        ob_last_next = ob_last_reg;
        ob_vec_next  = ob_vec_reg;
        ob_bits_next = ob_bits_reg;
        if (emit)
        begin
            ob_cnt_next  = ob_cnt_reg - NW_W'(1);
            ob_bits_next = ob_bits_reg - TW'(WORD_BITS);
        end
        if (fire)
        begin
            case (item.mode)
                MODE_ENCODE:
                begin
                    acc_next  = (WORD_BITS-1)'(vec & ~({ACC_W{1'b1}} << rem));
                    pend_next = PW'(rem);
                    if (nwords != '0)
                    begin
                        ob_cnt_next  = nwords;
                        ob_last_next = 1'b0;
                        ob_vec_next  = vec;
                        ob_bits_next = total;
                    end
                end
                MODE_FLUSH:
                begin
                    acc_next     = '0;
                    pend_next    = '0;
                    ob_cnt_next  = NW_W'(1);
                    ob_last_next = 1'b1;
                    ob_vec_next  = flush_vec;
                    ob_bits_next = TW'(WORD_BITS);
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            ob_cnt_reg  <= '0;
            ob_last_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            ob_cnt_reg  <= ob_cnt_next;
            ob_last_reg <= ob_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_vec_reg  <= ob_vec_next;
        ob_bits_reg <= ob_bits_next;
    end

    assign sh      = ob_bits_reg - TW'(WORD_BITS);
    assign word    = WORD_BITS'(ob_vec_reg >> sh);
    assign m_tlast = ob_last_reg;

    a_bits_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_cnt_reg != '0) |-> (ob_bits_reg >= TW'(WORD_BITS)))
        else $error("buffered bit count below one word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (out_words != '0)) |->
        ((ob_cnt_reg == '0) || ((ob_cnt_reg == NW_W'(1)) && m_tready)))
        else $error("word buffer overwritten while words remain");

    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_last_reg && (ob_cnt_reg != '0)) |-> (ob_cnt_reg == NW_W'(1)))
        else $error("last word buffered with further words");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.mode == MODE_FLUSH)) |=> ((pend_reg == '0) && (acc_reg == '0)))
        else $error("accumulator not empty after flush");

endmodule

@@ hdl/huffman_code_word_packer.sv @@
// Top level of the Huffman code word packer: input stage, code table, packer.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tuser mode; tdata symbol, code_value, code_length
//  m_*     | out | m_tvalid/m_tready  | tdata packed_word; tlast last
//
// One item per cycle for loads, flushes and encodes that release at most one word.
// An encode that releases n words keeps the word buffer busy until all are sent: the
// output port carries one word per cycle while m_tready is high. Items pass the table
// read, then the word buffer. Reset clears the accumulator and the buffers; the code
// table is not cleared. An item that releases words waits while the word buffer holds
// more than one word, or one word that is not taken in the same cycle.
module huffman_code_word_packer
    import hcwp_pkg::*;
#(
    parameter int SYMBOL_BITS  = 16,
    parameter int MAX_CODE_LEN = 32,
    parameter int WORD_BITS    = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,  // symbol, code_value, code_length
    input  logic [MODE_W-1:0]                   s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,  // packed_word
    output logic                                m_tlast
);

    localparam int M_TDATA_W = ((WORD_BITS + 7) / 8) * 8;

    logic [SYM_W-1:0]       in_symbol;
    logic [CODE_W-1:0]      in_code;
    logic [LEN_W-1:0]       in_len;
    logic [LEN_W-1:0]       in_len_sat;
    logic                   accept;
    logic                   s1_valid_reg, s1_valid_next;
    logic [MODE_W-1:0]      s1_mode_reg;
    logic [ENTRY_W-1:0]     rd_data;
    hcwp_item_t             item;
    logic                   item_ready;
    logic [WORD_BITS-1:0]   word;

    assign in_symbol  = s_tdata[SYM_W-1:0];
    assign in_code    = s_tdata[SYM_W+CODE_W-1:SYM_W];
    assign in_len     = s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
    assign in_len_sat = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;

    assign s_tready = !s1_valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= s_tuser;
        end
    end

    hcwp_code_mem #(
        .ADDR_W (SYMBOL_BITS)
    ) u_code_mem (
        .clk     (clk),
        .wr_en   (accept && (s_tuser == MODE_LOAD)),
        .wr_addr (in_symbol[SYMBOL_BITS-1:0]),
        .wr_data ({in_code, in_len_sat}),
        .rd_en   (accept && (s_tuser == MODE_ENCODE)),
        .rd_addr (in_symbol[SYMBOL_BITS-1:0]),
        .rd_data (rd_data)
    );

    assign item.mode = s1_mode_reg;
    assign item.code = rd_data[ENTRY_W-1:LEN_W];
    assign item.len  = rd_data[LEN_W-1:0];

    hcwp_packer #(
        .WORD_BITS (WORD_BITS)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item       (item),
        .item_ready (item_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .word       (word),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(word);

endmodule

@@ test/huffman_code_word_packer_test.sv @@
// Self-checking testbench for the Huffman code word packer: table loads, encodes, flushes.
`timescale 1ns / 100ps

module huffman_code_word_packer_test
    import hcwp_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int WORD_W = 16;
    localparam int CODE_MAX = 32;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } packed_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // symbol, code_value, code_length
    logic [MODE_W-1:0]     s_tuser;   // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [WORD_W-1:0]     m_tdata;   // packed_word
    logic                  m_tlast;

    // predicted encoder state
    logic [CODE_W-1:0]     tbl_code [int];
    logic [LEN_W-1:0]      tbl_len [int];
    int                    loaded_syms[$];
    logic [WORD_W-1:0]     acc_bits;
    int                    acc_count;
    packed_word_t          expected_words[$];

    int mismatches = 0;
    int n_items = 0;
    int n_load = 0;
    int n_encode = 0;
    int n_flush = 0;
    int n_noise = 0;
    int n_words = 0;

    // idling controls
    int tx_gap_max = 0;
    int tx_burst_left = 1;
    int rx_hold_max = 0;
    int rx_left = 0;

    huffman_code_word_packer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic void predict_words(input logic [MODE_W-1:0] mode,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [CODE_W-1:0] code,
                                          input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] bits;
        int                nbits;
        logic [31:0]       wide;
        packed_word_t      w;
        case (mode)
            MODE_LOAD:
            begin
                tbl_code[int'(sym)] = code;
                tbl_len[int'(sym)] = (len > CODE_MAX) ? LEN_W'(CODE_MAX) : len;
            end
            MODE_ENCODE:
            begin
                bits = tbl_code.exists(int'(sym)) ? tbl_code[int'(sym)] : '0;
                nbits = tbl_len.exists(int'(sym)) ? int'(tbl_len[int'(sym)]) : 0;
                for (int i = nbits - 1; i >= 0; i--)
                begin
                    acc_bits = {acc_bits[WORD_W-2:0], bits[i]};
                    acc_count++;
                    if (acc_count == WORD_W)
                    begin
                        w.word = acc_bits;
                        w.last = 1'b0;
                        expected_words.push_back(w);
                        acc_bits = '0;
                        acc_count = 0;
                    end
                end
            end
            MODE_FLUSH:
            begin
                wide = {16'b0, acc_bits} << (WORD_W - acc_count);
                w.word = wide[WORD_W-1:0];
                w.last = 1'b1;
                expected_words.push_back(w);
                acc_bits = '0;
                acc_count = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {2'b00, len, code, sym};
        do
            @(posedge clk);
        while (!s_tready);
        predict_words(mode, sym, code, len);
        n_items++;
        case (mode)
            MODE_LOAD:   n_load++;
            MODE_ENCODE: n_encode++;
            MODE_FLUSH:  n_flush++;
            default:     n_noise++;
        endcase
        tx_burst_left--;
        if (tx_burst_left <= 0)
        begin
            tx_burst_left = $urandom_range(1, 12);
            if (tx_gap_max > 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
            end
        end
    endtask

    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        send_item(MODE_ENCODE, sym, $urandom(), LEN_W'($urandom_range(0, 63)));
    endtask

    task automatic encode_random_loaded();
        encode_symbol(SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
    endtask

    task automatic load_random_entry(input bit reuse);
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        if (reuse && loaded_syms.size() > 0)
            sym = SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        else
            sym = SYM_W'($urandom());
        if ($urandom_range(0, 99) < 12)
            len = LEN_W'($urandom_range(0, 63));
        else
            len = LEN_W'($urandom_range(1, 20));
        if (!tbl_len.exists(int'(sym)))
            loaded_syms.push_back(int'(sym));
        send_item(MODE_LOAD, sym, $urandom(), len);
    endtask

    task automatic send_noise();
        send_item(MODE_UNUSED, SYM_W'($urandom()), $urandom(), LEN_W'($urandom_range(0, 63)));
    endtask

    task automatic set_idling(input int gap, input int hold);
        tx_gap_max = gap;
        rx_hold_max = hold;
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len);
        if (!tbl_len.exists(int'(sym)))
            loaded_syms.push_back(int'(sym));
        send_item(MODE_LOAD, sym, code, len);
    endtask

    task automatic test_directed_cases();
        set_idling(0, 0);
        send_item(MODE_FLUSH, 16'h0000, 32'h0, 6'd0);       // flush on empty accumulator
        load_entry(16'h0000, 32'h0000_0005, 6'd3);
        load_entry(16'hFFFF, 32'hFFFF_FFFF, 6'd32);
        load_entry(16'h0041, 32'h0000_0002, 6'd2);          // trailing odd byte value
        load_entry(16'h1234, 32'hABCD_1234, 6'd0);          // zero-length code
        load_entry(16'h8000, 32'h1234_5678, 6'd63);         // length saturates
        load_entry(16'h7FFF, 32'hFFFF_FF01, 6'd1);          // high code bits ignored
        load_entry(16'h00AA, 32'h0000_9C3F, 6'd16);
        send_noise();
        encode_symbol(16'h0000);
        encode_symbol(16'h1234);
        encode_symbol(16'hFFFF);
        encode_symbol(16'h0041);
        encode_symbol(16'h7FFF);
        send_item(MODE_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        encode_symbol(16'h00AA);
        send_item(MODE_FLUSH, 16'h0000, 32'h0, 6'd0);
        encode_symbol(16'h8000);
        encode_symbol(16'h0041);
        send_item(MODE_FLUSH, 16'h5555, 32'h0, 6'd0);
        send_item(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        encode_symbol(16'h0000);
        send_item(MODE_FLUSH, 16'h0000, 32'h0, 6'd0);
    endtask

    task automatic test_table_fill();
        set_idling(4, 3);
        repeat (96) load_random_entry(1'b0);
    endtask

    task automatic test_encode_frames();
        int frame_len;
        int pick;
        while (n_items < 1150)
        begin
            case ($urandom_range(0, 3))
                0: set_idling(0, 0);
                1: set_idling(3, 0);
                2: set_idling(0, 6);
                default: set_idling(10, 10);
            endcase
            frame_len = $urandom_range(1, 40);
            repeat (frame_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    load_random_entry($urandom_range(0, 1));
                else if (pick < 8)
                    send_noise();
                else
                    encode_random_loaded();
            end
            send_item(MODE_FLUSH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic test_noise_and_reload();
        set_idling(2, 4);
        repeat (120)
        begin
            case ($urandom_range(0, 3))
                MODE_LOAD:   load_random_entry(1'b1);
                MODE_ENCODE: encode_random_loaded();
                MODE_FLUSH:
                    send_item(MODE_FLUSH, SYM_W'($urandom()), $urandom(),
                              LEN_W'($urandom_range(0, 63)));
                default:     send_noise();
            endcase
        end
        send_item(MODE_FLUSH, 16'h0000, 32'h0, 6'd0);
    endtask

    // output stall pattern: random-length ready or stalled runs; no stalls when hold is 0
    always @(posedge clk)
    begin
        if (rx_hold_max == 0)
            m_tready <= 1'b1;
        else if (rx_left == 0)
        begin
            m_tready <= ($urandom_range(0, 2) != 0);
            rx_left <= $urandom_range(1, rx_hold_max);
        end
        else
            rx_left <= rx_left - 1;
    end

    always @(posedge clk)
    begin : check_words
        packed_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_words++;
            if (expected_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word %h last %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want.word || m_tlast !== want.last)
                begin
                    if (mismatches < 10)
                        $display("word %0d: expected %h last %b, got %h last %b",
                                 n_words, want.word, want.last, m_tdata, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        acc_bits = '0;
        acc_count = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= '0;
        s_tdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_fill();
        test_encode_frames();
        test_noise_and_reload();

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d loads, %0d encodes, %0d flushes, %0d unused-mode.",
                 n_items, n_load, n_encode, n_flush, n_noise);
        $display("Checked %0d packed words over %0d table entries, %0d mismatches.",
                 n_words, loaded_syms.size(), mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/hcwp_pkg.sv
hdl/hcwp_code_mem.sv
hdl/hcwp_packer.sv
hdl/huffman_code_word_packer.sv
test/huffman_code_word_packer_test.sv
